// ----- rtl/chr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants for the consistent-hash ring lookup core.
// ----------------------------------------------------------------------------
package chr_pkg;

  // FNV-1a 64 constants; the prime is 2^40 + 0x1b3
  localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO  = 9'h1b3;
  localparam int unsigned FNV_PRIME_SHL = 40;

  // input item kinds (tuser)
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // fixed field widths
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned HOST_W   = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 40;

  typedef struct packed {
    logic fold_start;   // capture acc ^ byte and the partial product
    logic fold_finish;  // add the shifted term back into the accumulator
    logic restart;      // reload the offset basis instead
  } fnv_ctrl_t;

  typedef struct packed {
    logic start;  // load lo = 0, hi = n
    logic step;   // compare read value against the hash, narrow the range
  } srch_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FOLD = 5'b00010,
    ST_SRD  = 5'b00100,
    ST_SCMP = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

// ----- rtl/consistent_hash_ring_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_core
// Ketama-style ring lookup: FNV-1a 64 key hash, binary search of ring points.
// ----------------------------------------------------------------------------
// Load item: written to the point table when taken (slot and host in range).
// Key byte: two-step FNV fold. After the final key byte, a binary search of
//   the ring points runs to the result register; each search probe is a RAM
//   read plus a compare on the one point-table read port.
// Result sits in an output register, so the next item is taken while it waits.
// Reset: async active low; hash returns to the offset basis, point_count to 1.
//   The point table is not cleared and must be loaded before lookups.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_core
  import chr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 4096,
  parameter int unsigned MAX_HOSTS  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config: point_count
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [COUNT_W-1:0]  cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // slot, point_value, point_host, key_byte
  input  logic                s_axis_tuser,  // req_type
  input  logic                s_axis_tlast,  // key_last
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // host_id, key_hash
);

  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned HOST_BITS = ($clog2(MAX_HOSTS) < HOST_W) ? $clog2(MAX_HOSTS) : HOST_W;
  localparam int unsigned ENTRY_W   = VALUE_W + HOST_BITS;

  state_e state_q, state_d;

  logic [COUNT_W-1:0] point_count_q;
  logic               last_q;
  logic [HASH_W-1:0]  hash_q;
  logic               out_valid_q;
  logic [HOST_W-1:0]  out_host_q;
  logic [HASH_W-1:0]  out_hash_q;

  logic [SLOT_W-1:0]  in_slot;
  logic [VALUE_W-1:0] in_value;
  logic [HOST_W-1:0]  in_host;
  logic [BYTE_W-1:0]  in_byte;

  logic in_accept, out_free, load_out;
  logic slot_ok, host_ok;
  logic [31:0]      cnt_ext;
  logic [CNT_W-1:0] n_c;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  fnv_ctrl_t          fnv_ctrl;
  logic [HASH_W-1:0]  fnv_hash;
  srch_ctrl_t         srch_ctrl;
  logic [IDX_W-1:0]   srch_mid, srch_result;
  logic               srch_done;

  assign in_slot  = s_axis_tdata[11:0];
  assign in_value = s_axis_tdata[43:12];
  assign in_host  = s_axis_tdata[51:44];
  assign in_byte  = s_axis_tdata[59:52];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= COUNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      point_count_q <= cfg_data_i;
    end
  end

  // zero counts as one, too many saturates
  assign cnt_ext = 32'(point_count_q);
  always_comb begin
    if (cnt_ext == 32'd0) begin
      n_c = CNT_W'(1);
    end else if (cnt_ext > 32'(MAX_POINTS)) begin
      n_c = CNT_W'(MAX_POINTS);
    end else begin
      n_c = CNT_W'(cnt_ext);
    end
  end

  // point loads
  assign slot_ok = 32'(in_slot) < 32'(MAX_POINTS);
  assign host_ok = 32'(in_host) < 32'(MAX_HOSTS);
  assign ram_we  = in_accept && (s_axis_tuser == REQ_LOAD) && slot_ok && host_ok;

  chr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(in_slot)),
    .wdata_i ({in_value, in_host[HOST_BITS-1:0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fnv_ctrl.fold_start  = in_accept && (s_axis_tuser == REQ_KEY);
  assign fnv_ctrl.fold_finish = (state_q == ST_FOLD);
  assign fnv_ctrl.restart     = last_q;

  chr_fnv u_fnv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fnv_ctrl),
    .byte_i (in_byte),
    .hash_o (fnv_hash)
  );

  assign srch_ctrl.start = (state_q == ST_FOLD) && last_q;
  assign srch_ctrl.step  = (state_q == ST_SCMP);

  chr_search #(
    .MAX_POINTS (MAX_POINTS)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (srch_ctrl),
    .n_i      (n_c),
    .hash_i   (hash_q),
    .value_i  (ram_rdata[ENTRY_W-1:HOST_BITS]),
    .mid_o    (srch_mid),
    .result_o (srch_result),
    .done_o   (srch_done)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign load_out = (state_q == ST_DONE) && out_free;

  // sequencer
  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_raddr = srch_mid;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == REQ_KEY)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_d = last_q ? ST_SRD : ST_IDLE;
      end
      ST_SRD: begin
        ram_re = 1'b1;
        if (srch_done) begin
          ram_raddr = srch_result;
          state_d   = ST_DONE;
        end else begin
          state_d   = ST_SCMP;
        end
      end
      ST_SCMP: begin
        state_d = ST_SRD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fnv_ctrl.fold_start) begin
        last_q <= s_axis_tlast;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch_ctrl.start) begin
      hash_q <= fnv_hash;
    end
    if (load_out) begin
      out_host_q <= HOST_W'(ram_rdata[HOST_BITS-1:0]);
      out_hash_q <= hash_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hash_q, out_host_q};

  // the table is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("point table read and write in the same cycle");

  // probes stay inside the valid points
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRD && !srch_done) |-> (CNT_W'(srch_mid) < n_c))
    else $error("search probe beyond point count");

  // a finished lookup shows up on the output next cycle
  a_result_presented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("lookup finished but no result presented");

  // no new item taken while a lookup is running
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCMP) |=> (state_q == ST_SRD) && !in_accept)
    else $error("search sequencing broken");

endmodule

// ----- rtl/chr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chr_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/chr_fnv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_fnv
// FNV-1a 64 accumulator; each key byte is folded in two steps (capture, then add).
// ----------------------------------------------------------------------------
module chr_fnv
  import chr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fnv_ctrl_t         ctrl_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic [HASH_W-1:0] hash_o
);

  logic [63:0] acc_q, acc_d;
  logic [63:0] x_q, p_q;
  logic [63:0] x_c;

  assign x_c = acc_q ^ {{(64-BYTE_W){1'b0}}, byte_i};

  // h * prime mod 2^64 = (h << 40) + h * 0x1b3
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fold_start) begin
      x_q <= x_c;
      p_q <= x_c * {55'd0, FNV_PRIME_LO};
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.fold_finish) begin
      if (ctrl_i.restart) begin
        acc_d = FNV_BASIS;
      end else begin
        acc_d = (x_q << FNV_PRIME_SHL) + p_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= FNV_BASIS;
    end else begin
      acc_q <= acc_d;
    end
  end

  // shifted term has no bits below 40, so the low word is the partial product
  assign hash_o = p_q[HASH_W-1:0];

endmodule

// ----- rtl/chr_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_search
// Lower-bound binary search state: range registers and the shared compare.
// ----------------------------------------------------------------------------
module chr_search
  import chr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srch_ctrl_t                        ctrl_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   n_i,
  input  logic [HASH_W-1:0]                 hash_i,
  input  logic [VALUE_W-1:0]                value_i,
  output logic [$clog2(MAX_POINTS)-1:0]     mid_o,
  output logic [$clog2(MAX_POINTS)-1:0]     result_o,
  output logic                              done_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0] mid_c;

  assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.start) begin
      lo_d = '0;
      hi_d = n_i;
    end else if (ctrl_i.step) begin
      if (value_i < hash_i) begin
        lo_d = CNT_W'(mid_c + 1'b1);
      end else begin
        hi_d = mid_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign mid_o    = mid_c[IDX_W-1:0];
  assign done_o   = !(lo_q < hi_q);
  // past the last point wraps to slot 0
  assign result_o = (hi_q >= n_i) ? '0 : hi_q[IDX_W-1:0];

endmodule

// ----- tb/sv/consistent_hash_ring_lookup_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_core_tb
// Self-checking bench for the ring lookup core: loads ring tables of several
// sizes (sorted, with duplicates, and now and then unsorted), streams keys
// byte by byte and compares each host/hash result against an in-bench model
// of the FNV-1a 64 hash and the ring binary search, under random idling.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_core_tb
  import chr_pkg::*;
();

  localparam int unsigned N_POINTS    = 4096;
  localparam int unsigned N_HOSTS     = 256;
  localparam int unsigned SETTLE_CYC  = 60;
  localparam logic [63:0] HASH_PRIME  = 64'h0000_0100_0000_01b3;
  localparam longint unsigned RUN_LIMIT_NS = 64'd30_000_000;

  // s_axis_tdata layout, lowest bits last in this list
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  key_byte;
    logic [7:0]  point_host;
    logic [31:0] point_value;
    logic [11:0] slot;
  } ring_item_t;

  typedef struct packed {
    logic [31:0] key_hash;
    logic [7:0]  host_id;
  } lookup_res_t;

  class ring_lookup_sb;
    logic [31:0]  pt_value [N_POINTS];
    logic [7:0]   pt_host  [N_POINTS];
    logic [63:0]  hash_acc;
    logic [12:0]  count_reg;
    lookup_res_t  lookups_q [$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < N_POINTS; i++) begin
        pt_value[i] = '0;
        pt_host[i]  = '0;
      end
      hash_acc  = FNV_BASIS;
      count_reg = 13'd1;
      errors    = 0;
    endfunction

    function void set_count(logic [12:0] v);
      count_reg = v;
    endfunction

    function logic [63:0] fold(logic [63:0] acc, logic [7:0] b);
      return (acc ^ {56'd0, b}) * HASH_PRIME;
    endfunction

    function logic [31:0] single_byte_hash(logic [7:0] b);
      logic [63:0] h;
      h = fold(FNV_BASIS, b);
      return h[31:0];
    endfunction

    // first point not below h, wrapping to slot 0
    function int unsigned ring_index(logic [31:0] h);
      int unsigned n, lo, hi, mid;
      n = 32'(count_reg);
      if (n == 0) n = 1;
      if (n > N_POINTS) n = N_POINTS;
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (pt_value[mid] < h) lo = mid + 1;
        else hi = mid;
      end
      return (hi >= n) ? 0 : hi;
    endfunction

    function void note_item(logic req, ring_item_t d, logic last);
      lookup_res_t r;
      if (req == REQ_LOAD) begin
        if (d.slot < N_POINTS && d.point_host < N_HOSTS) begin
          pt_value[d.slot] = d.point_value;
          pt_host[d.slot]  = d.point_host;
        end
        return;
      end
      hash_acc = fold(hash_acc, d.key_byte);
      if (!last) return;
      r.key_hash = hash_acc[31:0];
      r.host_id  = pt_host[ring_index(r.key_hash)];
      lookups_q.push_back(r);
      hash_acc = FNV_BASIS;
    endfunction

    function void check_result(lookup_res_t got);
      lookup_res_t exp;
      if (lookups_q.size() == 0) begin
        $display("%0t: unexpected result host %0h hash %08h", $time, got.host_id, got.key_hash);
        errors++;
        return;
      end
      exp = lookups_q.pop_front();
      if (got.host_id !== exp.host_id) begin
        $display("%0t: host_id mismatch exp %0h got %0h", $time, exp.host_id, got.host_id);
        errors++;
      end
      if (got.key_hash !== exp.key_hash) begin
        $display("%0t: key_hash mismatch exp %08h got %08h", $time, exp.key_hash, got.key_hash);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return lookups_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;  // slot, point_value, point_host, key_byte
  logic                s_axis_tuser = 1'b0;  // req_type
  logic                s_axis_tlast = 1'b0;  // key_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;  // host_id, key_hash

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  ring_lookup_sb sb = new();

  consistent_hash_ring_lookup_core #(
    .MAX_POINTS(N_POINTS),
    .MAX_HOSTS (N_HOSTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check on handshake, then pick the next ready
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(logic req, ring_item_t d, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(req, d, last);
    items_sent++;
  endtask

  task automatic send_load(int unsigned slot, logic [31:0] value, logic [7:0] host);
    ring_item_t d;
    d             = '0;
    d.slot        = 12'(slot);
    d.point_value = value;
    d.point_host  = host;
    d.key_byte    = 8'($urandom);
    send_item(REQ_LOAD, d, 1'($urandom_range(1)));
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    ring_item_t d;
    d             = '0;
    d.slot        = 12'($urandom);
    d.point_value = $urandom;
    d.point_host  = 8'($urandom);
    d.key_byte    = b;
    send_item(REQ_KEY, d, last);
  endtask

  // quiet the input side, let all lookups drain, then give the core time
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_point_count(logic [12:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_count(v);
  endtask

  // fill slots 0..n-1, ascending (duplicates allowed) unless scrambled
  task automatic load_ring(int unsigned n, bit scrambled);
    longint unsigned pos;
    int unsigned     step;
    logic [31:0]     v;
    pos  = 0;
    step = 32'hFFFF_FFFF / n;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(7) != 0) pos += $urandom_range(step);
      v = pos[31:0];
      if (i == n - 1 && $urandom_range(3) == 0) v = 32'hFFFF_FFFF;
      if (scrambled) v = $urandom;
      send_load(i, v, 8'($urandom));
    end
  endtask

  task automatic send_key(int unsigned n);
    int unsigned len, sel;
    sel = $urandom_range(9);
    if (sel < 6) len = $urandom_range(4, 1);
    else if (sel < 9) len = $urandom_range(12, 5);
    else len = $urandom_range(40, 13);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
      // stray load into an unused slot, mid-key
      if (i != len - 1 && n < N_POINTS && $urandom_range(9) == 0)
        send_load($urandom_range(N_POINTS - 1, n), $urandom, 8'($urandom));
    end
  endtask

  task automatic run_keys(int unsigned n, int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      send_key(n);
      if ($urandom_range(39) == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  initial begin
    logic [31:0] h;
    int unsigned n;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a point equal to the hash must win over the next one
    h = sb.single_byte_hash(8'h37);
    write_point_count(13'd2);
    send_load(0, h, 8'h00);
    send_load(1, 32'hFFFF_FFFF, 8'hFF);
    send_byte(8'h37, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // load between key bytes leaves the hash alone
    send_byte(8'h12, 1'b0);
    send_load(N_POINTS - 1, 32'h0, 8'hAA);
    send_byte(8'h34, 1'b1);
    drain_and_settle();
    // zero count acts as one point
    write_point_count(13'd0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    drain_and_settle();
    // all points below the hash: wrap to slot 0
    send_load(0, 32'h0, 8'h81);
    send_load(1, 32'h1, 8'h7E);
    drain_and_settle();
    write_point_count(13'd2);
    send_byte(8'h99, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    drain_and_settle();

    // random phases, mostly small rings
    for (int unsigned p = 0; p < 12; p++) begin
      set_idling(p);
      n = (p % 4 == 3) ? $urandom_range(200, 17) : $urandom_range(16, 1);
      load_ring(n, $urandom_range(5) == 0);
      drain_and_settle();
      write_point_count((n == 1 && $urandom_range(1) == 0) ? 13'd0 : n[12:0]);
      run_keys(n, 110);
      drain_and_settle();
    end

    // full-size and saturated counts: slot 0 and the power-of-two slots hold
    // the top value, so every search walks left through all of them to slot 0
    set_idling(0);
    send_load(0, 32'hFFFF_FFFF, 8'($urandom));
    for (int unsigned b = 0; b < 12; b++) send_load(1 << b, 32'hFFFF_FFFF, 8'($urandom));
    drain_and_settle();
    write_point_count(13'd4096);
    set_idling(3);
    run_keys(N_POINTS, 60);
    drain_and_settle();
    write_point_count(13'h1FFF);
    set_idling(1);
    run_keys(N_POINTS, 60);
    drain_and_settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
